/* design/iuc_pkg.sv */
// ----------------------------------------------------------------------------
// Interval union coverage package
// Shared types and constants for the interval coverage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package iuc_pkg;

  localparam int unsigned MaxIntervalsDef = 256;
  localparam int unsigned CoordBitsDef    = 32;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_LO,
    S_SCAN_HI,
    S_DECIDE,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_MRG_WRITE,
    S_MRG_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_lo;
    logic rd_hi;
    logic lo_inc;
    logic hi_inc;
    logic sub_span;
    logic ins_prep;
    logic ins_step;
    logic ins_write;
    logic mrg_write;
    logic mrg_step;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic lo_done;
    logic hi_done;
    logic none_hit;
    logic full;
    logic ins_done;
    logic mrg_done;
    logic rd_ok;
  } sts_t;

endpackage

`default_nettype wire

/* design/iuc_ctrl.sv */
// ----------------------------------------------------------------------------
// Interval union coverage controller
// Sequences the scan, insert and merge steps of one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module iuc_ctrl
  import iuc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  input  wire logic in_query_i,
  input  wire logic out_free_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o,
  output logic      resp_o,
  output logic [1:0] resp_status_o
);

  state_e state_q, state_d;
  logic [1:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= StOk;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    resp_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          if (in_query_i) begin
            st_d    = StOk;
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN_LO;
          end
        end
      end
      S_SCAN_LO: begin
        if (sts_i.bad) begin
          st_d    = StBad;
          state_d = S_RESP;
        end else if (sts_i.rd_ok) begin
          if (sts_i.lo_done) begin
            cmd_o.rd_hi = 1'b1;
            state_d     = S_SCAN_HI;
          end else begin
            cmd_o.lo_inc = 1'b1;
            cmd_o.rd_lo  = 1'b1;
          end
        end else begin
          cmd_o.rd_lo = 1'b1;
        end
      end
      S_SCAN_HI: begin
        if (sts_i.rd_ok) begin
          if (sts_i.hi_done) begin
            state_d = S_DECIDE;
          end else begin
            cmd_o.hi_inc   = 1'b1;
            cmd_o.sub_span = 1'b1;
            cmd_o.rd_hi    = 1'b1;
          end
        end else begin
          cmd_o.rd_hi = 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts_i.none_hit) begin
          if (sts_i.full) begin
            st_d    = StFull;
            state_d = S_RESP;
          end else begin
            cmd_o.ins_prep = 1'b1;
            state_d        = S_INS_SHIFT;
          end
        end else begin
          cmd_o.mrg_write = 1'b1;
          state_d         = S_MRG_SHIFT;
        end
      end
      S_INS_SHIFT: begin
        if (sts_i.ins_done) begin
          state_d = S_INS_WRITE;
        end else begin
          cmd_o.ins_step = 1'b1;
        end
      end
      S_INS_WRITE: begin
        cmd_o.ins_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_MRG_WRITE: begin
        state_d = S_MRG_SHIFT;
      end
      S_MRG_SHIFT: begin
        if (sts_i.mrg_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.mrg_step = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          resp_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign resp_status_o = st_q;

endmodule

`default_nettype wire

/* design/iuc_dp.sv */
// ----------------------------------------------------------------------------
// Interval union coverage datapath
// Holds the interval table memories, scan pointers and the coverage total.
// ----------------------------------------------------------------------------
`default_nettype none

module iuc_dp
  import iuc_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervalsDef,
  parameter int unsigned COORD_BITS    = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  input  wire logic [COORD_BITS-1:0] start_i,
  input  wire logic [COORD_BITS-1:0] end_i,
  input  wire logic [COORD_BITS-1:0] line_len_i,
  output sts_t                       sts_o,
  output logic [31:0]                total_o
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_INTERVALS);

  logic [COORD_BITS-1:0] mem_s [MAX_INTERVALS];
  logic [COORD_BITS-1:0] mem_e [MAX_INTERVALS];

  logic [COORD_BITS-1:0] s_q, e_q, rs_q, re_q, ns_q, ne_q;
  logic [CW-1:0] cnt_q, lo_q, hi_q, ptr_q;
  logic [31:0]   tot_q, acc_q;
  logic          rv_q, first_q, sv_q;

  logic [AW-1:0] raddr;
  logic          rd;
  logic          we;
  logic [AW-1:0] waddr;
  logic [COORD_BITS-1:0] wd_s, wd_e;
  logic [CW-1:0] k;
  logic [31:0]   span_new;

  logic          sw_rd;
  logic [AW-1:0] sw_addr;
  logic [CW-1:0] sw_dst;
  logic [COORD_BITS-1:0] sw_s, sw_e;
  logic [CW-1:0] dst_q;

  assign k = hi_q - lo_q;

  // The high scan starts on the entry where the low scan stopped.
  always_comb begin
    rd    = 1'b0;
    raddr = lo_q[AW-1:0];
    if (cmd_i.rd_lo) begin
      rd    = 1'b1;
      raddr = cmd_i.lo_inc ? AW'(lo_q + 1'b1) : lo_q[AW-1:0];
    end else if (cmd_i.rd_hi) begin
      rd    = 1'b1;
      raddr = cmd_i.hi_inc ? AW'(hi_q + 1'b1) : lo_q[AW-1:0];
    end
  end

  // Shift sweeps read one entry a cycle and write it to its new slot in the following cycle.
  always_comb begin
    we    = 1'b0;
    waddr = lo_q[AW-1:0];
    wd_s  = ns_q;
    wd_e  = ne_q;
    if (cmd_i.ins_write) begin
      we = 1'b1;
      wd_s = s_q;
      wd_e = e_q;
    end else if (cmd_i.mrg_write) begin
      we = 1'b1;
    end else if (sv_q) begin
      we    = 1'b1;
      wd_s  = sw_s;
      wd_e  = sw_e;
      waddr = dst_q[AW-1:0];
    end
  end

  always_comb begin
    sw_rd   = 1'b0;
    sw_addr = '0;
    sw_dst  = ptr_q;
    if (cmd_i.ins_step) begin
      sw_rd   = 1'b1;
      sw_addr = AW'(ptr_q - 1'b1);
    end else if (cmd_i.mrg_step) begin
      sw_rd   = 1'b1;
      sw_addr = AW'(ptr_q);
      sw_dst  = ptr_q - k + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_s[waddr] <= wd_s;
      mem_e[waddr] <= wd_e;
    end
    rs_q <= mem_s[raddr];
    re_q <= mem_e[raddr];
    sw_s <= mem_s[sw_addr];
    sw_e <= mem_e[sw_addr];
  end

  assign span_new = 32'(ne_q - ns_q) + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      tot_q   <= '0;
      rv_q    <= 1'b0;
      sv_q    <= 1'b0;
      first_q <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
      dst_q   <= '0;
    end else begin
      rv_q <= rd;
      sv_q <= sw_rd;
      if (sw_rd) begin
        dst_q <= sw_dst;
      end
      if (cmd_i.load) begin
        lo_q    <= '0;
        first_q <= 1'b1;
      end
      if (cmd_i.lo_inc) begin
        lo_q <= lo_q + 1'b1;
      end
      if (cmd_i.rd_hi && !cmd_i.hi_inc) begin
        hi_q <= lo_q;
      end
      if (cmd_i.hi_inc) begin
        hi_q    <= hi_q + 1'b1;
        first_q <= 1'b0;
      end
      if (cmd_i.ins_prep) begin
        ptr_q <= cnt_q;
      end
      if (cmd_i.ins_step) begin
        ptr_q <= ptr_q - 1'b1;
      end
      if (cmd_i.mrg_write) begin
        ptr_q <= hi_q;
      end
      if (cmd_i.mrg_step) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.ins_write) begin
        cnt_q <= cnt_q + 1'b1;
        tot_q <= tot_q + span_new;
      end
      if (cmd_i.mrg_write) begin
        cnt_q <= cnt_q - k + 1'b1;
        tot_q <= acc_q + span_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q   <= start_i;
      e_q   <= end_i;
      ns_q  <= start_i;
      ne_q  <= end_i;
      acc_q <= tot_q;
    end
    if (cmd_i.ins_write) begin
      ns_q <= s_q;
      ne_q <= e_q;
    end
    if (cmd_i.sub_span) begin
      acc_q <= acc_q - (32'(re_q - rs_q) + 32'd1);
      if (first_q && rs_q < s_q) begin
        ns_q <= rs_q;
      end
      if (re_q > e_q) begin
        ne_q <= re_q;
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.bad      = (s_q == '0) || (e_q < s_q) || (e_q > line_len_i);
    sts_o.rd_ok    = rv_q;
    sts_o.lo_done  = (lo_q >= cnt_q) || (re_q >= s_q);
    sts_o.hi_done  = (hi_q >= cnt_q) || (rs_q > e_q);
    sts_o.none_hit = (hi_q == lo_q);
    sts_o.full     = (cnt_q >= MaxCnt);
    sts_o.ins_done = (ptr_q == lo_q);
    sts_o.mrg_done = (ptr_q >= cnt_q + k - 1'b1);
  end

  assign total_o = tot_q;

endmodule

`default_nettype wire

/* design/interval_union_coverage.sv */
// ----------------------------------------------------------------------------
// Interval union coverage tracker
// Keeps a sorted table of disjoint intervals and their covered position count.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis; tuser holds func, tdata range_start, range_end.
// Queries and dropped adds give one beat on m_axis with covered_count in
// tdata and status in tuser; accepted adds give none.
// One item is handled at a time. A query goes from idle straight to the
// response state, and its result is registered onto m_axis; the next beat
// can be taken once the block is back in idle. A bad range is caught in the
// low scan state and goes from there to the response state. An add scans
// the table, then inserts, shifting later entries up, or merges, shifting
// later entries down; an add dropped on a full table only scans.
// line_length must be written by cfg_we_i only while the block is idle;
// the block does not enforce this. Reset empties the table, clears the
// count and sets line_length to all ones; the table memory itself is not
// swept. When m_axis_tready is low the result beat is held, and a further
// result waits, with no new beat taken, until the held one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_union_coverage
  import iuc_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervalsDef,
  parameter int unsigned COORD_BITS    = CoordBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // range_start, range_end
  input  wire logic        s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // covered_count
  output logic [1:0]       m_axis_tuser   // status
);

  logic [COORD_BITS-1:0] len_q;
  logic [31:0] cnt_q;
  logic [1:0]  st_q;
  logic        ov_q;
  cmd_t cmd;
  sts_t sts;
  logic busy, resp, in_fire;
  logic [1:0] resp_st;
  logic [31:0] total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '1;
      ov_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i[COORD_BITS-1:0];
      end
      if (resp) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp) begin
      cnt_q <= total;
      st_q  <= resp_st;
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = cnt_q;
  assign m_axis_tuser  = st_q;

  iuc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .in_query_i   (s_axis_tuser),
    .out_free_i   (!ov_q || m_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .resp_o       (resp),
    .resp_status_o(resp_st)
  );

  iuc_dp #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .start_i   (s_axis_tdata[COORD_BITS-1:0]),
    .end_i     (s_axis_tdata[COORD_BITS+31:32]),
    .line_len_i(len_q),
    .sts_o     (sts),
    .total_o   (total)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy)
    else $error("accepted beat did not start work");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("bad status code");

endmodule

`default_nettype wire
